// File: design/u2dh_pkg.sv
// Package for the uniform 2-D histogram: payload structs, FSM states, constants.
// No dependencies.
package u2dh_pkg;

  localparam int unsigned DefMaxRows  = 64;
  localparam int unsigned DefMaxCols  = 64;
  localparam int unsigned DefCountBits = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivW     = 33;  // span and offset are 33-bit values

  typedef enum logic [CfgIdxW-1:0] {
    CfgXLow    = 3'd0,
    CfgXHigh   = 3'd1,
    CfgYLow    = 3'd2,
    CfgYHigh   = 3'd3,
    CfgColCnt  = 3'd4,
    CfgRowCnt  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CmdAdd  = 1'b0,
    CmdRead = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        command;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic [5:0]  row_select;
    logic [5:0]  col_select;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic [31:0] cell_count;
  } out_item_t;

  typedef enum logic [3:0] {
    StClear, StIdle, StDiv, StRead, StWait, StWrite, StDone
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the transaction, start division
    logic div_step;   // one quotient bit on both axes
    logic mem_rd;     // issue cell read
    logic mem_wr;     // write back incremented cell
    logic clr_wr;     // write zero at clear pointer
    logic emit;       // drive result strobe
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
    logic clr_last;
    logic is_add;
    logic valid;      // add: point lands in range; read: selected cell within configured bins
  } stat_t;

endpackage

// File: design/u2dh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module u2dh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[addr_i];
  end
endmodule

// File: design/u2dh_ctrl.sv
// Controller FSM: clear sweep, division steps, read-modify-write sequence.
// Depends on u2dh_pkg.
module u2dh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  u2dh_pkg::stat_t stat_i,
  output u2dh_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import u2dh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    case (state_q)
      StClear: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = StRead;
      end
      StRead: begin
        if (stat_i.valid) begin
          ctrl_o.mem_rd = 1'b1;
          state_d = StWait;
        end else begin
          state_d = StDone;
        end
      end
      StWait: begin
        state_d = stat_i.is_add ? StWrite : StDone;
      end
      StWrite: begin
        ctrl_o.mem_wr = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        ctrl_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// File: design/u2dh_dp.sv
// Datapath: config registers, two bit-serial dividers, count RAM and result register.
// Depends on u2dh_pkg and u2dh_ram.
module u2dh_dp #(
  parameter int unsigned MaxRows   = u2dh_pkg::DefMaxRows,
  parameter int unsigned MaxCols   = u2dh_pkg::DefMaxCols,
  parameter int unsigned CountBits = u2dh_pkg::DefCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [u2dh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [u2dh_pkg::CfgDataW-1:0]  cfg_data_i,
  input  u2dh_pkg::in_item_t             item_i,
  input  u2dh_pkg::ctrl_t                ctrl_i,
  output u2dh_pkg::stat_t                stat_o,
  output logic                           res_valid_o,
  output u2dh_pkg::out_item_t            res_o
);
  import u2dh_pkg::*;

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RowW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  // quotient numerator is off*n with n <= 127: 33 + 7 bits
  localparam int unsigned NumW  = DivW + 7;
  localparam int unsigned StepW = $clog2(NumW + 1);
  localparam logic [6:0]  MaxRows7 = (MaxRows > 127) ? 7'd127 : 7'(MaxRows);
  localparam logic [6:0]  MaxCols7 = (MaxCols > 127) ? 7'd127 : 7'(MaxCols);

  // configuration
  logic [31:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [6:0]  col_cnt_q, row_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q   <= 32'd0;
      x_high_q  <= 32'd65536;
      y_low_q   <= 32'd0;
      y_high_q  <= 32'd65536;
      col_cnt_q <= 7'd64;
      row_cnt_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgXLow:   x_low_q   <= cfg_data_i;
        CfgXHigh:  x_high_q  <= cfg_data_i;
        CfgYLow:   y_low_q   <= cfg_data_i;
        CfgYHigh:  y_high_q  <= cfg_data_i;
        CfgColCnt: col_cnt_q <= cfg_data_i[6:0];
        CfgRowCnt: row_cnt_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective bin counts (clamped to the array size)
  logic [6:0] nc, nr;
  assign nc = (col_cnt_q > MaxCols7) ? MaxCols7 : col_cnt_q;
  assign nr = (row_cnt_q > MaxRows7) ? MaxRows7 : row_cnt_q;

  // range checks, done on capture
  logic signed [DivW-1:0] xv, xl, xh, yv, yl, yh;
  assign xv = DivW'($signed(item_i.x_coord));
  assign xl = DivW'($signed(x_low_q));
  assign xh = DivW'($signed(x_high_q));
  assign yv = DivW'($signed(item_i.y_coord));
  assign yl = DivW'($signed(y_low_q));
  assign yh = DivW'($signed(y_high_q));

  logic x_in, y_in;
  assign x_in = (nc != 7'd0) && (xh > xl) && (xv >= xl) && (xv < xh);
  assign y_in = (nr != 7'd0) && (yh > yl) && (yv >= yl) && (yv < yh);

  // transaction registers
  logic           cmd_q, valid_q;
  logic [5:0]     rsel_q, csel_q;
  logic [6:0]     nc_q, nr_q;
  logic [NumW-1:0] xnum_q, ynum_q;   // numerator shifts out MSB first
  logic [DivW-1:0] xden_q, yden_q;
  logic [DivW-1:0] xrem_q, yrem_q;
  logic [NumW-1:0] xquo_q, yquo_q;
  logic [StepW-1:0] step_q;

  logic [DivW-1:0] xoff, yoff;
  assign xoff = DivW'(xv - xl);
  assign yoff = DivW'(yv - yl);

  // one restoring step per cycle on each axis (multiplication by n is a
  // 33x7 product at load)
  logic [DivW:0] xtry, ytry;
  assign xtry = {xrem_q, xnum_q[NumW-1]};
  assign ytry = {yrem_q, ynum_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (ctrl_i.load) begin
      step_q <= '0;
    end else if (ctrl_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= item_i.command;
      rsel_q  <= item_i.row_select;
      csel_q  <= item_i.col_select;
      nc_q    <= nc;
      nr_q    <= nr;
      valid_q <= (item_i.command == CmdRead)
               ? ((7'(item_i.row_select) < nr) && (7'(item_i.col_select) < nc))
               : (x_in && y_in);
      xnum_q  <= NumW'(xoff) * NumW'(nc);
      ynum_q  <= NumW'(yoff) * NumW'(nr);
      xden_q  <= DivW'(xh - xl);
      yden_q  <= DivW'(yh - yl);
      xrem_q  <= '0;
      yrem_q  <= '0;
      xquo_q  <= '0;
      yquo_q  <= '0;
    end else if (ctrl_i.div_step) begin
      xnum_q <= {xnum_q[NumW-2:0], 1'b0};
      ynum_q <= {ynum_q[NumW-2:0], 1'b0};
      if (xtry >= {1'b0, xden_q}) begin
        xrem_q <= DivW'(xtry - {1'b0, xden_q});
        xquo_q <= {xquo_q[NumW-2:0], 1'b1};
      end else begin
        xrem_q <= DivW'(xtry);
        xquo_q <= {xquo_q[NumW-2:0], 1'b0};
      end
      if (ytry >= {1'b0, yden_q}) begin
        yrem_q <= DivW'(ytry - {1'b0, yden_q});
        yquo_q <= {yquo_q[NumW-2:0], 1'b1};
      end else begin
        yrem_q <= DivW'(ytry);
        yquo_q <= {yquo_q[NumW-2:0], 1'b0};
      end
    end
  end

  // bins; off < span so quotient < n already, clamp kept for safety
  logic [6:0] cbin, rbin;
  assign cbin = (xquo_q >= NumW'(nc_q)) ? nc_q - 7'd1 : xquo_q[6:0];
  assign rbin = (yquo_q >= NumW'(nr_q)) ? nr_q - 7'd1 : yquo_q[6:0];

  logic [RowW-1:0] row_a;
  logic [ColW-1:0] col_a;
  assign row_a = (cmd_q == CmdRead) ? RowW'(rsel_q) : RowW'(rbin);
  assign col_a = (cmd_q == CmdRead) ? ColW'(csel_q) : ColW'(cbin);

  // clear sweep pointer
  logic [AddrW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          clr_q <= '0;
    else if (ctrl_i.clr_wr) clr_q <= clr_q + AddrW'(1);
  end

  logic [AddrW-1:0] cell_a, addr;
  assign cell_a = AddrW'(AddrW'(row_a) * AddrW'(MaxCols) + AddrW'(col_a));
  assign addr   = ctrl_i.clr_wr ? clr_q : cell_a;

  logic [CountBits-1:0] rdata, incd;
  assign incd = (&rdata) ? rdata : rdata + CountBits'(1);

  u2dh_ram #(.Width(CountBits), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.clr_wr | ctrl_i.mem_wr),
    .re_i    (ctrl_i.mem_rd),
    .addr_i  (addr),
    .wdata_i (ctrl_i.clr_wr ? '0 : incd),
    .rdata_o (rdata)
  );

  // result holds rdata for reads, incremented value for adds
  logic [CountBits-1:0] cnt_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr)                cnt_q <= incd;
    else if (ctrl_i.mem_rd)           cnt_q <= '0;
  end

  logic [CountBits-1:0] cnt_out;
  assign cnt_out = (cmd_q == CmdRead) ? rdata : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_o <= 1'b0;
    else         res_valid_o <= ctrl_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      res_o.hit <= valid_q;
      if (cmd_q == CmdRead) begin
        res_o.row_index  <= rsel_q;
        res_o.col_index  <= csel_q;
        res_o.cell_count <= valid_q ? 32'(cnt_out) : 32'd0;
      end else begin
        res_o.row_index  <= valid_q ? rbin[5:0] : 6'd0;
        res_o.col_index  <= valid_q ? cbin[5:0] : 6'd0;
        res_o.cell_count <= valid_q ? 32'(cnt_out) : 32'd0;
      end
    end
  end

  assign stat_o.div_last = (step_q == StepW'(NumW - 1));
  assign stat_o.clr_last = (clr_q == AddrW'(Depth - 1));
  assign stat_o.is_add   = (cmd_q == CmdAdd);
  assign stat_o.valid    = valid_q;
endmodule

// File: design/uniform_2d_histogram.sv
// Uniform-bin 2-D histogram over signed Q16.16 points, with saturating cell counts.
// One transaction at a time: the bit-serial dividers run, then, for a valid item,
// the count RAM is read and, for an add, written back; a new start is taken only once
// busy drops after the result. After reset a clearing pass writes zero to all
// MAX_ROWS*MAX_COLS cells (4096 by default) while busy is high; the receiver cannot
// stall, so each result is valid for exactly one cycle.
module uniform_2d_histogram #(
  parameter int unsigned MAX_ROWS   = u2dh_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS   = u2dh_pkg::DefMaxCols,
  parameter int unsigned COUNT_BITS = u2dh_pkg::DefCountBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [u2dh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [u2dh_pkg::CfgDataW-1:0] cfg_data_i,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  u2dh_pkg::in_item_t            item_i,
  // result channel
  output logic                          res_valid_o,
  output u2dh_pkg::out_item_t           res_o
);
  import u2dh_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: clear sweep, then per transaction divide -> read (if valid) -> write (adds) -> emit
  u2dh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // datapath: config regs, dividers, count RAM
  u2dh_dp #(
    .MaxRows   (MAX_ROWS),
    .MaxCols   (MAX_COLS),
    .CountBits (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );
endmodule
